@@ design/ngfe_pkg.sv @@
`default_nettype none

package ngfe_pkg;

	localparam int HDR_LEN = 7;
	localparam int MATCH_W = 3;
	localparam int COMMA_W = 3;
	localparam int POS_W   = 4;
	localparam int FID_W   = 3;

	localparam logic [7:0] LINE_END = 8'h0A;
	localparam logic [7:0] COMMA_CH = 8'h2C;
	localparam logic [7:0] ZERO_CH  = 8'h30;

	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_TIMEOUT = 1'b1;

	localparam logic [COMMA_W-1:0] CM_LAT = 3'd1;
	localparam logic [COMMA_W-1:0] CM_NS  = 3'd2;
	localparam logic [COMMA_W-1:0] CM_LON = 3'd3;
	localparam logic [COMMA_W-1:0] CM_EW  = 3'd4;
	localparam logic [COMMA_W-1:0] CM_FQ  = 3'd5;
	localparam logic [COMMA_W-1:0] CM_SAT = 3'd6;

	localparam logic [FID_W-1:0] FID_LAT = 3'd0;
	localparam logic [FID_W-1:0] FID_NS  = 3'd1;
	localparam logic [FID_W-1:0] FID_LON = 3'd2;
	localparam logic [FID_W-1:0] FID_EW  = 3'd3;
	localparam logic [FID_W-1:0] FID_FQ  = 3'd4;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [FID_W-1:0] field_id;
		logic [POS_W-1:0] char_pos;
		logic [7:0]       char_value;
		logic             has_fix;
		logic             last;
	} out_item_t;

	typedef struct packed {
		logic [7:0] ns;
		logic [7:0] ew;
		logic [7:0] fq;
	} sentence_t;

	typedef struct packed {
		logic [FID_W-1:0] field_id;
		logic [POS_W-1:0] char_pos;
		logic             from_mem;
		logic [7:0]       value;
		logic             has_fix;
		logic             last;
	} issue_t;

	typedef enum logic [2:0] {
		DR_IDLE,
		DR_LAT,
		DR_NS,
		DR_LON,
		DR_EW,
		DR_FQ
	} drain_state_t;

	function automatic logic [7:0] header_char(input logic [MATCH_W-1:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h24;
			3'd1: c = 8'h47;
			3'd2: c = 8'h50;
			3'd3: c = 8'h47;
			3'd4: c = 8'h47;
			3'd5: c = 8'h41;
			3'd6: c = 8'h2C;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

@@ design/ngfe_ram.sv @@
`default_nettype none

module ngfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 30
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ design/ngfe_parse.sv @@
`default_nettype none

module ngfe_parse
	import ngfe_pkg::*;
#(
	parameter int MAX_FIELD_CHARS = 15,
	parameter int IDX_W           = $clog2(MAX_FIELD_CHARS + 1),
	parameter int ADDR_W          = $clog2(2 * MAX_FIELD_CHARS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire in_item_t          item,
	output      logic              we,
	output      logic [ADDR_W-1:0] waddr,
	output      logic [7:0]        wdata,
	output      logic              start,
	output      logic [IDX_W-1:0]  lat_len,
	output      logic [IDX_W-1:0]  lon_len,
	output      sentence_t         sent
);

	logic [MATCH_W-1:0] match_q, match_d, match_next;
	logic               found_q, found_d;
	logic [COMMA_W-1:0] comma_q, comma_d;
	logic [IDX_W-1:0]   cidx_q, cidx_d, cidx_inc;
	logic [IDX_W-1:0]   lat_len_q, lat_len_d, lon_len_q, lon_len_d;
	sentence_t          sent_q, sent_d;
	logic [7:0]         b;
	logic               room;

	assign b        = item.data_byte;
	assign cidx_inc = cidx_q + IDX_W'(1);
	assign room     = cidx_q < IDX_W'(MAX_FIELD_CHARS);

	always_comb begin
		if ((match_q < MATCH_W'(HDR_LEN)) && (b == header_char(match_q))) begin
			match_next = match_q + MATCH_W'(1);
		end else if (b == header_char('0)) begin
			match_next = MATCH_W'(1);
		end else begin
			match_next = '0;
		end
	end

	always_comb begin
		match_d   = match_q;
		found_d   = found_q;
		comma_d   = comma_q;
		cidx_d    = cidx_q;
		lat_len_d = lat_len_q;
		lon_len_d = lon_len_q;
		sent_d    = sent_q;
		we        = 1'b0;
		waddr     = ADDR_W'(cidx_q);
		wdata     = b;
		start     = 1'b0;
		if (accept) begin
			if ((item.kind == KIND_TIMEOUT) || (b == LINE_END)) begin
				start     = (item.kind == KIND_BYTE) && found_q;
				match_d   = '0;
				found_d   = 1'b0;
				comma_d   = '0;
				cidx_d    = '0;
				lat_len_d = '0;
				lon_len_d = '0;
				sent_d    = '0;
			end else if (!found_q) begin
				if (match_next == MATCH_W'(HDR_LEN)) begin
					found_d = 1'b1;
					match_d = '0;
				end else begin
					match_d = match_next;
				end
			end else if (b == COMMA_CH) begin
				if (comma_q < CM_SAT) begin
					comma_d = comma_q + COMMA_W'(1);
				end
				cidx_d = '0;
			end else begin
				case (comma_q)
					CM_LAT: begin
						if (room) begin
							we        = 1'b1;
							cidx_d    = cidx_inc;
							lat_len_d = cidx_inc;
						end
					end
					CM_NS: sent_d.ns = b;
					CM_LON: begin
						if (room) begin
							we        = 1'b1;
							waddr     = ADDR_W'(MAX_FIELD_CHARS) + ADDR_W'(cidx_q);
							cidx_d    = cidx_inc;
							lon_len_d = cidx_inc;
						end
					end
					CM_EW: sent_d.ew = b;
					CM_FQ: sent_d.fq = b;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q   <= '0;
			found_q   <= 1'b0;
			comma_q   <= '0;
			cidx_q    <= '0;
			lat_len_q <= '0;
			lon_len_q <= '0;
			sent_q    <= '0;
		end else begin
			match_q   <= match_d;
			found_q   <= found_d;
			comma_q   <= comma_d;
			cidx_q    <= cidx_d;
			lat_len_q <= lat_len_d;
			lon_len_q <= lon_len_d;
			sent_q    <= sent_d;
		end
	end

	assign lat_len = lat_len_q;
	assign lon_len = lon_len_q;
	assign sent    = sent_q;

endmodule

`default_nettype wire

@@ design/ngfe_drain.sv @@
`default_nettype none

module ngfe_drain
	import ngfe_pkg::*;
#(
	parameter int MAX_FIELD_CHARS = 15,
	parameter int IDX_W           = $clog2(MAX_FIELD_CHARS + 1),
	parameter int ADDR_W          = $clog2(2 * MAX_FIELD_CHARS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [IDX_W-1:0]  lat_len,
	input  wire logic [IDX_W-1:0]  lon_len,
	input  wire sentence_t         sent,
	output      logic              busy,
	output      logic              ram_re,
	output      logic [ADDR_W-1:0] ram_raddr,
	input  wire logic [7:0]        ram_rdata,
	output      logic              fld_valid,
	input  wire logic              fld_ready,
	output      out_item_t         fld_item
);

	drain_state_t     state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] lat_len_q, lon_len_q, cur_len;
	sentence_t        snap_q;
	logic             has_fix_q;
	issue_t           meta, meta_s1;
	logic             valid_s1, adv_s1, issue, field_done;
	out_item_t        item_s2;
	logic             valid_s2;

	assign adv_s1 = valid_s1 && (!valid_s2 || fld_ready);
	assign issue  = (state_q != DR_IDLE) && (!valid_s1 || adv_s1);
	assign busy   = state_q != DR_IDLE;

	always_comb begin
		meta         = '0;
		meta.has_fix = has_fix_q;
		cur_len      = '0;
		ram_raddr    = ADDR_W'(idx_q);
		case (state_q)
			DR_LAT: begin
				cur_len       = lat_len_q;
				meta.field_id = FID_LAT;
				meta.char_pos = POS_W'(idx_q);
				meta.from_mem = lat_len_q != '0;
			end
			DR_NS: begin
				meta.field_id = FID_NS;
				meta.value    = snap_q.ns;
			end
			DR_LON: begin
				cur_len       = lon_len_q;
				meta.field_id = FID_LON;
				meta.char_pos = POS_W'(idx_q);
				meta.from_mem = lon_len_q != '0;
				ram_raddr     = ADDR_W'(MAX_FIELD_CHARS) + ADDR_W'(idx_q);
			end
			DR_EW: begin
				meta.field_id = FID_EW;
				meta.value    = snap_q.ew;
			end
			DR_FQ: begin
				meta.field_id = FID_FQ;
				meta.value    = snap_q.fq;
				meta.last     = 1'b1;
			end
			default: ;
		endcase
		field_done = (cur_len == '0) || (IDX_W'(idx_q + IDX_W'(1)) == cur_len);
		ram_re     = issue && meta.from_mem;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			DR_IDLE: if (start) state_d = DR_LAT;
			DR_LAT:  if (issue && field_done) state_d = DR_NS;
			DR_NS:   if (issue) state_d = DR_LON;
			DR_LON:  if (issue && field_done) state_d = DR_EW;
			DR_EW:   if (issue) state_d = DR_FQ;
			DR_FQ:   if (issue) state_d = DR_IDLE;
			default: state_d = DR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= DR_IDLE;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= field_done ? '0 : idx_q + IDX_W'(1);
			end
			valid_s1 <= issue || (valid_s1 && !adv_s1);
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (fld_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			lat_len_q <= lat_len;
			lon_len_q <= lon_len;
			snap_q    <= sent;
			has_fix_q <= sent.fq != ZERO_CH;
		end
		if (issue) begin
			meta_s1 <= meta;
		end
		if (adv_s1) begin
			item_s2.field_id   <= meta_s1.field_id;
			item_s2.char_pos   <= meta_s1.char_pos;
			item_s2.char_value <= meta_s1.from_mem ? ram_rdata : meta_s1.value;
			item_s2.has_fix    <= meta_s1.has_fix;
			item_s2.last       <= meta_s1.last;
		end
	end

	assign fld_valid = valid_s2;
	assign fld_item  = item_s2;

endmodule

`default_nettype wire

@@ design/nmea_gga_field_extractor.sv @@
// Channel | Dir | Payload    | Transfer
// rx      | in  | in_item_t  | rx_valid && rx_ready: one receiver byte or a timeout
// fld     | out | out_item_t | fld_valid && fld_ready: one captured character
//
// One rx item per cycle while no sentence is being read out.
// A newline that ends a found sentence holds rx_ready low while the drain
// sequencer reads the captured characters from the character RAM (one read port),
// one character a cycle while fld_ready is high and longer while it is low.
// Reset clears all control and line state; the character RAM is not cleared.
`default_nettype none

module nmea_gga_field_extractor
	import ngfe_pkg::*;
#(
	parameter int MAX_FIELD_CHARS = 15
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      rx_valid,
	output      logic      rx_ready,
	input  wire in_item_t  rx_item,
	output      logic      fld_valid,
	input  wire logic      fld_ready,
	output      out_item_t fld_item
);

	localparam int IDX_W  = $clog2(MAX_FIELD_CHARS + 1);
	localparam int DEPTH  = 2 * MAX_FIELD_CHARS;
	localparam int ADDR_W = $clog2(DEPTH);

	logic              accept, start, busy;
	logic              we, re;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [7:0]        wdata, rdata;
	logic [IDX_W-1:0]  lat_len, lon_len;
	sentence_t         sent;

	assign rx_ready = !busy;
	assign accept   = rx_valid && rx_ready;

	ngfe_parse #(
		.MAX_FIELD_CHARS(MAX_FIELD_CHARS),
		.IDX_W(IDX_W),
		.ADDR_W(ADDR_W)
	) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.item(rx_item),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.start(start),
		.lat_len(lat_len),
		.lon_len(lon_len),
		.sent(sent)
	);

	ngfe_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(re),
		.raddr(raddr),
		.rdata(rdata)
	);

	ngfe_drain #(
		.MAX_FIELD_CHARS(MAX_FIELD_CHARS),
		.IDX_W(IDX_W),
		.ADDR_W(ADDR_W)
	) u_drain (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.lat_len(lat_len),
		.lon_len(lon_len),
		.sent(sent),
		.busy(busy),
		.ram_re(re),
		.ram_raddr(raddr),
		.ram_rdata(rdata),
		.fld_valid(fld_valid),
		.fld_ready(fld_ready),
		.fld_item(fld_item)
	);

endmodule

`default_nettype wire

@@ design/ngfe_chk.sv @@
`default_nettype none

module ngfe_chk
	import ngfe_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      rx_valid,
	input wire logic      rx_ready,
	input wire in_item_t  rx_item,
	input wire logic      fld_valid,
	input wire logic      fld_ready,
	input wire out_item_t fld_item
);

	a_fld_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fld_valid && !fld_ready |=> fld_valid && $stable(fld_item))
		else $error("fld payload changed while stalled");

	a_last_is_quality: assert property (@(posedge clk) disable iff (!arst_n)
		fld_valid |-> (fld_item.last == (fld_item.field_id == FID_FQ)))
		else $error("last flag does not match fix quality field");

	a_single_char_pos: assert property (@(posedge clk) disable iff (!arst_n)
		fld_valid && (fld_item.field_id == FID_NS || fld_item.field_id == FID_EW ||
			fld_item.field_id == FID_FQ) |-> fld_item.char_pos == '0)
		else $error("nonzero position on single-character field");

	a_timeout_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid && rx_ready && rx_item.kind == KIND_TIMEOUT |=> rx_ready)
		else $error("timeout transfer stalled rx");

	a_fix_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(fld_valid && fld_ready && !fld_item.last) ##1 fld_valid |->
			fld_item.has_fix == $past(fld_item.has_fix))
		else $error("has_fix changed within a sentence");

endmodule

bind nmea_gga_field_extractor ngfe_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.rx_valid(rx_valid),
	.rx_ready(rx_ready),
	.rx_item(rx_item),
	.fld_valid(fld_valid),
	.fld_ready(fld_ready),
	.fld_item(fld_item)
);

`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ngfe_pkg::*;

	localparam int MAX_CHARS   = 15;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 3000;
	localparam int RAND_ITEMS  = 150;
	localparam int CALM_ITEMS  = 40;
	localparam int TAIL_CYCLES = 40;
	localparam logic [55:0] GGA_TEXT = "$GPGGA,";
	localparam logic [7:0]  CR_CH    = 8'h0D;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      rx_valid  = 1'b0;
	logic      rx_ready;
	in_item_t  rx_item   = '0;
	logic      fld_valid;
	logic      fld_ready = 1'b0;
	out_item_t fld_item;

	logic tx_idle   = 1'b0;
	logic rx_idle   = 1'b0;
	logic hold_req  = 1'b0;
	logic hold_done = 1'b0;
	int   stall_left = 0;

	class gga_field_tracker;
		out_item_t          due_fields[$];
		int                 errors;
		int                 matched;
		int                 rx_count;
		int                 timeouts;
		int                 sentences;
		logic [2:0]         hdr_pos;
		logic               found;
		logic [COMMA_W-1:0] commas;
		logic [4:0]         idx;
		logic [4:0]         lat_len;
		logic [4:0]         lon_len;
		logic [7:0]         lat_chars [MAX_CHARS];
		logic [7:0]         lon_chars [MAX_CHARS];
		logic [7:0]         ns_char;
		logic [7:0]         ew_char;
		logic [7:0]         fq_char;

		function new();
			foreach (lat_chars[i]) begin
				lat_chars[i] = '0;
				lon_chars[i] = '0;
			end
			clear_line();
		endfunction

		function void clear_line();
			hdr_pos = '0;
			found   = 1'b0;
			commas  = '0;
			idx     = '0;
			lat_len = '0;
			lon_len = '0;
			ns_char = '0;
			ew_char = '0;
			fq_char = '0;
		endfunction

		function logic [7:0] gga_text_char(input logic [2:0] pos);
			return GGA_TEXT[8 * (6 - pos) +: 8];
		endfunction

		function void add_field(input logic [FID_W-1:0] fid, input int pos,
				input logic [7:0] val, input logic fix, input logic lst);
			out_item_t e;
			e.field_id   = fid;
			e.char_pos   = POS_W'(pos);
			e.char_value = val;
			e.has_fix    = fix;
			e.last       = lst;
			due_fields.push_back(e);
		endfunction

		function void add_coord(input logic [FID_W-1:0] fid,
				input logic [7:0] chars [MAX_CHARS], input logic [4:0] len,
				input logic fix);
			if (len == 0) begin
				add_field(fid, 0, 8'h00, fix, 1'b0);
			end else begin
				for (int i = 0; i < len; i++)
					add_field(fid, i, chars[i], fix, 1'b0);
			end
		endfunction

		function void take_rx(input in_item_t it);
			logic       fix;
			logic [7:0] b;
			b = it.data_byte;
			rx_count++;
			if (it.kind == KIND_TIMEOUT) begin
				timeouts++;
				clear_line();
				return;
			end
			if (b == LINE_END) begin
				if (found) begin
					fix = (fq_char != ZERO_CH);
					add_coord(FID_LAT, lat_chars, lat_len, fix);
					add_field(FID_NS, 0, ns_char, fix, 1'b0);
					add_coord(FID_LON, lon_chars, lon_len, fix);
					add_field(FID_EW, 0, ew_char, fix, 1'b0);
					add_field(FID_FQ, 0, fq_char, fix, 1'b1);
					sentences++;
				end
				clear_line();
				return;
			end
			if (!found) begin
				if (b == gga_text_char(hdr_pos))
					hdr_pos++;
				else
					hdr_pos = (b == gga_text_char(3'd0)) ? 3'd1 : 3'd0;
				if (hdr_pos == 3'(HDR_LEN)) begin
					found   = 1'b1;
					hdr_pos = '0;
				end
				return;
			end
			if (b == COMMA_CH) begin
				if (commas < CM_SAT)
					commas++;
				idx = '0;
				return;
			end
			case (commas)
				CM_LAT: begin
					if (idx < MAX_CHARS) begin
						lat_chars[idx] = b;
						idx++;
						lat_len = idx;
					end
				end
				CM_NS: ns_char = b;
				CM_LON: begin
					if (idx < MAX_CHARS) begin
						lon_chars[idx] = b;
						idx++;
						lon_len = idx;
					end
				end
				CM_EW: ew_char = b;
				CM_FQ: fq_char = b;
				default: ;
			endcase
		endfunction

		task report(input string msg);
			errors++;
			$display("%0t ns  mismatch: %s", $time, msg);
		endtask

		task match_field(input out_item_t got);
			out_item_t want;
			if (due_fields.size() == 0) begin
				report($sformatf("unexpected result fid=%0d pos=%0d val=%02h",
					got.field_id, got.char_pos, got.char_value));
				return;
			end
			want = due_fields.pop_front();
			matched++;
			if (got.field_id !== want.field_id)
				report($sformatf("field_id %0d, want %0d", got.field_id, want.field_id));
			if (got.char_pos !== want.char_pos)
				report($sformatf("char_pos %0d, want %0d (fid %0d)",
					got.char_pos, want.char_pos, want.field_id));
			if (got.char_value !== want.char_value)
				report($sformatf("char_value %02h, want %02h (fid %0d pos %0d)",
					got.char_value, want.char_value, want.field_id, want.char_pos));
			if (got.has_fix !== want.has_fix)
				report($sformatf("has_fix %0b, want %0b", got.has_fix, want.has_fix));
			if (got.last !== want.last)
				report($sformatf("last %0b, want %0b (fid %0d)",
					got.last, want.last, want.field_id));
		endtask
	endclass

	gga_field_tracker tracker;

	nmea_gga_field_extractor #(
		.MAX_FIELD_CHARS(MAX_CHARS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_item  (rx_item),
		.fld_valid(fld_valid),
		.fld_ready(fld_ready),
		.fld_item (fld_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && fld_valid && fld_ready)
			tracker.match_field(fld_item);
		if (hold_req && !hold_done) begin
			hold_done  = 1'b1;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			fld_ready <= 1'b0;
		end else if (rx_idle && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 16);
			fld_ready <= 1'b0;
		end else begin
			fld_ready <= 1'b1;
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((rx_valid && rx_ready) || (fld_valid && fld_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
		$display("status: fail");
		$finish;
	end

	task automatic send_item(input logic kind, input logic [7:0] b);
		in_item_t it;
		int       gap;
		if (tx_idle && $urandom_range(0, 9) == 0) begin
			rx_valid <= 1'b0;
			gap = $urandom_range(1, 17);
			repeat (gap) @(posedge clk);
		end
		it.kind      = kind;
		it.data_byte = b;
		rx_valid <= 1'b1;
		rx_item  <= it;
		do @(posedge clk); while (!rx_ready);
		tracker.take_rx(it);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(KIND_BYTE, b);
	endtask

	task automatic send_timeout();
		send_item(KIND_TIMEOUT, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// hold the sender until every pending result has been taken
	task automatic wait_drained();
		rx_valid <= 1'b0;
		do @(posedge clk); while (tracker.due_fields.size() != 0);
	endtask

	function automatic logic [7:0] digit_char();
		return ZERO_CH + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] noise_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == LINE_END);
		return c;
	endfunction

	function automatic logic [7:0] pick_char(input logic [COMMA_W-1:0] f);
		logic [7:0] c;
		if ($urandom_range(0, 3) == 0) begin
			do c = 8'($urandom_range(0, 255)); while (c == LINE_END || c == COMMA_CH);
		end else begin
			case (f)
				CM_NS: c = $urandom_range(0, 1) ? "N" : "S";
				CM_EW: c = $urandom_range(0, 1) ? "E" : "W";
				CM_FQ: c = ZERO_CH + 8'($urandom_range(0, 2));
				default: c = ($urandom_range(0, 9) == 0) ? "." : digit_char();
			endcase
		end
		return c;
	endfunction

	task automatic send_random_line();
		int                 n;
		int                 nf;
		logic [COMMA_W-1:0] f;
		if ($urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 4);
			repeat (n) send_byte(noise_char());
		end
		if ($urandom_range(0, 14) == 0) begin
			send_byte(LINE_END);
			return;
		end
		if ($urandom_range(0, 7) == 0)
			send_text("$GPG");
		send_text("$GPGGA,");
		n = $urandom_range(0, 6);
		repeat (n) send_byte(digit_char());
		nf = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : 5;
		for (f = CM_LAT; f <= CM_FQ && f <= nf; f++) begin
			send_byte(COMMA_CH);
			if (f == CM_LAT || f == CM_LON)
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 11);
			else
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 1;
			repeat (n) send_byte(pick_char(f));
		end
		if (nf == 5 && $urandom_range(0, 1) == 1) begin
			n = $urandom_range(1, 4);
			repeat (n) begin
				send_byte(COMMA_CH);
				send_byte(digit_char());
			end
			if ($urandom_range(0, 1) == 1)
				send_byte(CR_CH);
		end
		if ($urandom_range(0, 11) == 0)
			send_timeout();
		else
			send_byte(LINE_END);
	endtask

	initial begin
		int base;
		int lines;
		tracker = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle = 1'b1;
		rx_idle <= 1'b1;

		send_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n");
		send_text("$GPGGA,,,,,,0\n");
		send_text("$GPGGA,\n");
		send_text("$GPGGA,,");
		send_byte(8'h00);
		send_text("12345678901234567,NS,");
		send_byte(8'hFF);
		send_text("23456789ABCDEF,EW,2\n");
		send_text("GPGGA,1,2,N\n");
		send_text("$GP$$GPGGA,,7,S\n");
		send_text("x$GPGGA,,$GPGGA,,1\n");
		send_text("$GPGGA,,12");
		send_timeout();
		send_text(",3,N\n");
		send_item(KIND_TIMEOUT, LINE_END);
		send_item(KIND_TIMEOUT, 8'hFF);
		send_text("$GPGGA,,1,N,2,E,6,,,,,,,,\r\n");
		send_text("$GPGGA,,1,N,2,E,,5\n");
		send_byte(LINE_END);
		wait_drained();

		base  = tracker.rx_count;
		lines = 0;
		while (tracker.rx_count - base < RAND_ITEMS) begin
			if (tracker.rx_count - base >= RAND_ITEMS - CALM_ITEMS) begin
				tx_idle = 1'b0;
				rx_idle <= 1'b0;
			end else begin
				tx_idle = ($urandom_range(0, 2) != 0);
				rx_idle <= ($urandom_range(0, 2) != 0);
			end
			if (lines == 1)
				hold_req <= 1'b1;
			if (lines == 3)
				wait_drained();
			send_random_line();
			lines++;
		end
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run: %0d receiver transfers, %0d idle timeouts, %0d GGA sentences",
			tracker.rx_count, tracker.timeouts, tracker.sentences);
		$display("run: %0d field characters checked, %0d mismatches",
			tracker.matched, tracker.errors);
		if (tracker.errors == 0 && tracker.due_fields.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ nmea_gga_field_extractor.f @@
design/ngfe_pkg.sv
design/ngfe_ram.sv
design/ngfe_parse.sv
design/ngfe_drain.sv
design/nmea_gga_field_extractor.sv
design/ngfe_chk.sv
sim/tb_top.sv
